@@ hw/rtl/sao_pkg.sv @@
package sao_pkg;

  localparam int unsigned CB    = 8;
  localparam int unsigned DW    = 2 * CB + 1;
  localparam int unsigned NW    = 3 * CB + 1;
  localparam int unsigned NLANE = 4;
  localparam int unsigned IN_W  = 2 * NLANE * CB;
  localparam int unsigned OUT_W = ((NLANE * CB + 7) / 8) * 8;

  localparam int unsigned LANE_ALPHA = 0;
  localparam int unsigned LANE_RED   = 1;

  localparam logic [CB-1:0] CHAN_MAX  = {CB{1'b1}};
  localparam logic [DW-1:0] ALPHA_DEN = DW'({CHAN_MAX, 1'b0});

  typedef logic [CB-1:0] chan_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [CB-1:0] sh;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lane;
    logic [DW-1:0]     den;
    logic              bypass;
    chan_t [NLANE-1:0] under;
  } div_t;

endpackage

@@ hw/rtl/sao_front.sv @@
module sao_front (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  sao_pkg::chan_t [sao_pkg::NLANE-1:0]      under_i,
  input  sao_pkg::chan_t [sao_pkg::NLANE-1:0]      top_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output sao_pkg::div_t                            data_o
);

  localparam int unsigned CB = sao_pkg::CB;
  localparam int unsigned NC = sao_pkg::NLANE - 1;

  typedef struct packed {
    logic [2*CB-1:0]                        uat;
    logic [NC-1:0][2*CB-1:0]                pt;
    logic [NC-1:0][2*CB-1:0]                pu;
    logic [CB-1:0]                          mat;
    logic [CB:0]                            sum;
    logic                                   bypass;
    sao_pkg::chan_t [sao_pkg::NLANE-1:0]    under;
  } f1_t;

  typedef struct packed {
    logic [2*CB-1:0]                        an;
    logic [NC-1:0][3*CB-1:0]                ctm;
    logic [NC-1:0][3*CB-1:0]                cuw;
    logic                                   bypass;
    sao_pkg::chan_t [sao_pkg::NLANE-1:0]    under;
  } f2_t;

  logic          v1_q, v2_q, v3_q;
  logic          rdy1, rdy2, rdy3;
  f1_t           s1_d, s1_q;
  f2_t           s2_d, s2_q;
  sao_pkg::div_t s3_d, s3_q;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;
  assign data_o  = s3_q;

  // products of the inputs
  always_comb begin
    logic [CB-1:0] au, at;
    au = under_i[sao_pkg::LANE_ALPHA];
    at = top_i[sao_pkg::LANE_ALPHA];
    s1_d.uat = (2*CB)'(au) * (2*CB)'(at);
    for (int i = 0; i < NC; i++) begin
      s1_d.pt[i] = (2*CB)'(top_i[i+1]) * (2*CB)'(at);
      s1_d.pu[i] = (2*CB)'(under_i[i+1]) * (2*CB)'(au);
    end
    s1_d.mat    = sao_pkg::CHAN_MAX - at;
    s1_d.sum    = (CB+1)'(au) + (CB+1)'(at);
    s1_d.bypass = (at == '0);
    s1_d.under  = under_i;
  end

  // alpha numerator and weighted colour terms
  always_comb begin
    logic [2*CB:0] an_w;
    an_w = {s1_q.sum, {CB{1'b0}}} - (2*CB+1)'(s1_q.sum) - (2*CB+1)'(s1_q.uat);
    s2_d.an = an_w[2*CB-1:0];
    for (int i = 0; i < NC; i++) begin
      s2_d.ctm[i] = {s1_q.pt[i], {CB{1'b0}}} - (3*CB)'(s1_q.pt[i]);
      s2_d.cuw[i] = (3*CB)'(s1_q.pu[i]) * (3*CB)'(s1_q.mat);
    end
    s2_d.bypass = s1_q.bypass;
    s2_d.under  = s1_q.under;
  end

  // rounded dividends and divisor
  always_comb begin
    logic [3*CB-1:0]          cn;
    logic [sao_pkg::NW-1:0]   n;
    cn = '0;
    n  = sao_pkg::NW'({s2_q.an, 1'b0}) + sao_pkg::NW'(sao_pkg::CHAN_MAX);
    s3_d.lane[sao_pkg::LANE_ALPHA].rem = n[sao_pkg::NW-1:CB];
    s3_d.lane[sao_pkg::LANE_ALPHA].sh  = n[CB-1:0];
    for (int i = 0; i < NC; i++) begin
      cn = s2_q.ctm[i] + s2_q.cuw[i];
      n  = {cn, 1'b0} + sao_pkg::NW'(s2_q.an);
      s3_d.lane[sao_pkg::LANE_RED+i].rem = n[sao_pkg::NW-1:CB];
      s3_d.lane[sao_pkg::LANE_RED+i].sh  = n[CB-1:0];
    end
    s3_d.den    = {s2_q.an, 1'b0};
    s3_d.bypass = s2_q.bypass;
    s3_d.under  = s2_q.under;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)    s2_q <= s2_d;
    if (rdy3 && v2_q)    s3_q <= s3_d;
  end

endmodule

@@ hw/rtl/sao_div_step.sv @@
module sao_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  sao_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output sao_pkg::div_t data_o
);

  localparam int unsigned CB = sao_pkg::CB;
  localparam int unsigned DW = sao_pkg::DW;

  logic          v_q;
  sao_pkg::div_t d_d, d_q;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign data_o  = d_q;

  // one restoring step per lane
  always_comb begin
    logic [DW:0]   t, dd, diff;
    logic          ge;
    d_d = data_i;
    for (int i = 0; i < sao_pkg::NLANE; i++) begin
      dd   = (i == sao_pkg::LANE_ALPHA) ? {1'b0, sao_pkg::ALPHA_DEN} : {1'b0, data_i.den};
      t    = {data_i.lane[i].rem, data_i.lane[i].sh[CB-1]};
      diff = t - dd;
      ge   = (t >= dd);
      d_d.lane[i].rem = ge ? diff[DW-1:0] : t[DW-1:0];
      d_d.lane[i].sh  = {data_i.lane[i].sh[CB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) d_q <= d_d;
  end

endmodule

@@ hw/rtl/straight_alpha_over_blend.sv @@
// straight-alpha over compositing, one pixel pair per item
// s_axis carries the under pixel and the top pixel, 8 channels of CB
// bits each; m_axis carries the composited pixel, alpha first.
// a top alpha of zero passes the under pixel through unchanged. otherwise
// alpha and the three colours come from one rounded division each.
// the datapath is 3 arithmetic stages (products, scaled terms, dividends),
// then one restoring-division stage per quotient bit for all four channels
// side by side, then the output register.
// throughput: one item per cycle while m_axis_tready is high, set by the
// one-step-per-stage divider.
// every stage holds its own valid bit and takes new data while it is empty
// or its successor moves, so bubbles close up under a stall.
// when m_axis_tready is low the output holds its item and the stages behind
// it keep filling; s_axis_tready falls only once every stage is full.
// reset clears all valid bits; items in flight are dropped.
module straight_alpha_over_blend (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // under_alpha, under_red, under_green, under_blue,
  // top_alpha, top_red, top_green, top_blue
  input  logic [sao_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // blend_alpha, blend_red, blend_green, blend_blue
  output logic [sao_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int unsigned CB = sao_pkg::CB;
  localparam int unsigned NL = sao_pkg::NLANE;

  sao_pkg::chan_t [NL-1:0] under, top;
  sao_pkg::div_t           chain [0:CB];
  logic                    vchain [0:CB];
  logic                    rchain [0:CB];

  logic                    out_v_q;
  sao_pkg::chan_t [NL-1:0] out_d, out_q;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      under[i] = s_axis_tdata[i*CB +: CB];
      top[i]   = s_axis_tdata[(i+NL)*CB +: CB];
    end
  end

  sao_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .under_i (under),
    .top_i   (top),
    .valid_o (vchain[0]),
    .ready_i (rchain[0]),
    .data_o  (chain[0])
  );

  for (genvar g = 0; g < CB; g++) begin : g_div
    sao_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vchain[g]),
      .ready_o (rchain[g]),
      .data_i  (chain[g]),
      .valid_o (vchain[g+1]),
      .ready_i (rchain[g+1]),
      .data_o  (chain[g+1])
    );
  end

  assign rchain[CB] = !out_v_q || m_axis_tready;

  // quotients never exceed the channel maximum
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      out_d[i] = chain[CB].bypass ? chain[CB].under[i] : chain[CB].lane[i].sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rchain[CB]) begin
      out_v_q <= vchain[CB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rchain[CB] && vchain[CB]) out_q <= out_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = sao_pkg::OUT_W'(out_q);

endmodule

@@ dv/straight_alpha_over_blend_tb.sv @@
module straight_alpha_over_blend_tb;

  import sao_pkg::*;

  localparam longint unsigned CMAX = (64'd1 << CB) - 64'd1;
  localparam int unsigned IDLE_MAX = 18;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;

  logic [OUT_W-1:0]    expected_blends[$];
  int unsigned         mismatch_count = 0;
  int unsigned         tx_gap_max     = 0;
  int unsigned         rx_stall_max   = 0;

  always #10 clk_i = ~clk_i;

  straight_alpha_over_blend dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [IN_W-1:0] pack_pixel(input chan_t ua, input chan_t ur,
                                                 input chan_t ug, input chan_t ub,
                                                 input chan_t ta, input chan_t tr,
                                                 input chan_t tg, input chan_t tb);
    return {tb, tg, tr, ta, ub, ug, ur, ua};
  endfunction

  function automatic chan_t mix_colour(input longint unsigned ct, input longint unsigned at,
                                       input longint unsigned cu, input longint unsigned au,
                                       input longint unsigned an);
    longint unsigned num;
    longint unsigned q;
    num = ct * at * CMAX + cu * au * (CMAX - at);
    q   = (2 * num + an) / (2 * an);
    if (q > CMAX) begin
      q = CMAX;
    end
    return chan_t'(q);
  endfunction

  function automatic logic [OUT_W-1:0] blend_pixel(input logic [IN_W-1:0] px);
    longint unsigned au, ur, ug, ub, at, tr, tg, tb, an;
    logic [OUT_W-1:0] res;
    au = px[0*CB +: CB];
    ur = px[1*CB +: CB];
    ug = px[2*CB +: CB];
    ub = px[3*CB +: CB];
    at = px[4*CB +: CB];
    tr = px[5*CB +: CB];
    tg = px[6*CB +: CB];
    tb = px[7*CB +: CB];
    res = '0;
    if (at == 0) begin
      // transparent top, under pixel passes through
      res[NLANE*CB-1:0] = px[NLANE*CB-1:0];
    end else begin
      an = CMAX * (au + at) - au * at;
      res[LANE_ALPHA*CB +: CB] = chan_t'((2 * an + CMAX) / (2 * CMAX));
      res[(LANE_RED+0)*CB +: CB] = mix_colour(tr, at, ur, au, an);
      res[(LANE_RED+1)*CB +: CB] = mix_colour(tg, at, ug, au, an);
      res[(LANE_RED+2)*CB +: CB] = mix_colour(tb, at, ub, au, an);
    end
    return res;
  endfunction

  function automatic logic [IN_W-1:0] random_pixel();
    logic [IN_W-1:0] px;
    int unsigned     sel;
    px  = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    case (sel)
      0: px[4*CB +: CB] = '0;
      1: px[4*CB +: CB] = CHAN_MAX;
      2: px[0*CB +: CB] = '0;
      3: px[0*CB +: CB] = CHAN_MAX;
      4: px[4*CB +: CB] = chan_t'($urandom_range(1, 3));
      5: begin
        px[0*CB +: CB] = CHAN_MAX;
        px[4*CB +: CB] = CHAN_MAX;
      end
      default: ;
    endcase
    return px;
  endfunction

  // leaves tvalid high after the accepting edge so back-to-back items need no toggle
  task automatic send_pixel(input logic [IN_W-1:0] px);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_blends.push_back(blend_pixel(px));
  endtask

  task automatic test_extremes();
    tx_gap_max   = 0;
    rx_stall_max = 0;
    send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(pack_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(pack_pixel(8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00));
    send_pixel(pack_pixel(8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(pack_pixel(8'hff, 8'hff, 8'h00, 8'h80, 8'h01, 8'h00, 8'hff, 8'h80));
    send_pixel(pack_pixel(8'h00, 8'h12, 8'h34, 8'h56, 8'h01, 8'hff, 8'h00, 8'h7f));
    send_pixel(pack_pixel(8'h01, 8'hff, 8'hff, 8'hff, 8'h01, 8'h00, 8'h00, 8'h00));
    send_pixel(pack_pixel(8'hfe, 8'h01, 8'hfe, 8'h7f, 8'hfe, 8'hfe, 8'h01, 8'h80));
    send_pixel(pack_pixel(8'h55, 8'h55, 8'h55, 8'h55, 8'haa, 8'haa, 8'haa, 8'haa));
    send_pixel(pack_pixel(8'haa, 8'haa, 8'haa, 8'haa, 8'h55, 8'h55, 8'h55, 8'h55));
    send_pixel(pack_pixel(8'h80, 8'hff, 8'hff, 8'hff, 8'h80, 8'hff, 8'hff, 8'hff));
    send_pixel(pack_pixel(8'h80, 8'h00, 8'h00, 8'h00, 8'h7f, 8'h00, 8'h00, 8'h00));
    send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'hff, 8'hff));
  endtask

  task automatic test_transparent_top();
    tx_gap_max   = IDLE_MAX;
    rx_stall_max = IDLE_MAX;
    send_pixel(pack_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff));
    send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff));
    send_pixel(pack_pixel(8'h00, 8'h9c, 8'h3e, 8'h71, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(pack_pixel(8'h5a, 8'ha5, 8'h5a, 8'ha5, 8'h00, 8'ha5, 8'h5a, 8'ha5));
    for (int i = 0; i < 6; i++) begin
      send_pixel(pack_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom),
                            chan_t'($urandom), 8'h00, chan_t'($urandom),
                            chan_t'($urandom), chan_t'($urandom)));
    end
  endtask

  task automatic test_random_blend();
    for (int blk = 0; blk < 8; blk++) begin
      tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
      rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
      repeat (50) send_pixel(random_pixel());
    end
  endtask

  task automatic test_full_rate();
    tx_gap_max   = 0;
    rx_stall_max = 0;
    repeat (60) send_pixel(random_pixel());
    // stalls at the output only, so the pipe fills and input ready drops
    rx_stall_max = IDLE_MAX;
    repeat (60) send_pixel(random_pixel());
  endtask

  // output side: random stalls before each item
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  string lane_name[NLANE] = '{"alpha", "red", "green", "blue"};

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_blends.size() == 0) begin
        $display("%0t: unexpected item, actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        logic [OUT_W-1:0] exp_px;
        exp_px = expected_blends.pop_front();
        for (int k = 0; k < NLANE; k++) begin
          if (m_axis_tdata[k*CB +: CB] !== exp_px[k*CB +: CB]) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, lane_name[k],
                     exp_px[k*CB +: CB], m_axis_tdata[k*CB +: CB]);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_transparent_top();
    test_random_blend();
    test_full_rate();
    s_axis_tvalid <= 1'b0;
    while (expected_blends.size() != 0) @(posedge clk_i);
    repeat (CB + 12) @(posedge clk_i);
    if (mismatch_count == 0 && expected_blends.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
